/* hw/rtl/cdtl_pkg.sv */
package cdtl_pkg;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_RUN  = 2'd2;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_LOADING = 2'd1;
  localparam logic [1:0] ST_COMMIT  = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam logic [31:0] SUM_SEED = 32'hF00D8421;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 10;
  localparam int DATA_W    = 16;
  localparam int OUT_ROW_W = 9;

  typedef struct packed {
    logic [1:0]           status;
    logic                 running;
    logic [OUT_ROW_W-1:0] rows;
    logic                 rd_hit;
  } res_t;

endpackage

/* hw/rtl/cdtl_ram.sv */
module cdtl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* hw/rtl/cdtl_ctrl.sv */
module cdtl_ctrl #(
  parameter int ROW_CAPACITY = 512,
  parameter int MIN_ROWS     = 29,
  parameter int ENTRY_WIDTH  = 16,
  localparam int ROW_W       = $clog2(ROW_CAPACITY),
  localparam int POS_W       = ROW_W + 1,
  localparam int AW          = POS_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        item_en,
  input  logic [1:0]                  op,
  input  logic [cdtl_pkg::WORD_W-1:0] load_word,
  input  logic [cdtl_pkg::ADDR_W-1:0] read_address,
  input  logic                        run_value,
  output cdtl_pkg::res_t              res,
  output logic                        ram_we,
  output logic                        ram_re,
  output logic [AW-1:0]               ram_addr,
  output logic [ENTRY_WIDTH-1:0]      ram_wdata
);

  typedef enum logic [1:0] {PH_COUNT, PH_SUM, PH_ENTRY} phase_t;

  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      sum_r, sum_nxt;
  logic [31:0]      expect_r, expect_nxt;
  logic [ROW_W-1:0] rows_r, rows_nxt;
  logic [ROW_W-1:0] act_rows_r, act_rows_nxt;
  logic             bank_r, bank_nxt;
  logic             run_r, run_nxt;

  logic [POS_W-1:0] last;
  logic [POS_W:0]   pinc;
  logic [31:0]      entry_sum;
  logic             bad_count;
  logic [31:0]      addr32;
  logic             rd_in_range;
  logic [31:0]      rows32;

  always_comb begin
    last        = {rows_r, 1'b0} - POS_W'(1);
    pinc        = {1'b0, pos_r} + (POS_W + 1)'(1);
    entry_sum   = sum_r + load_word + 32'(pinc[POS_W:1]);
    bad_count   = (load_word >= 32'(ROW_CAPACITY)) || (load_word < 32'(MIN_ROWS));
    addr32      = 32'(read_address);
    rd_in_range = (addr32 < 32'({act_rows_r, 1'b0})) && (addr32 < 32'(2 * ROW_CAPACITY));

    phase_nxt    = phase_r;
    pos_nxt      = pos_r;
    sum_nxt      = sum_r;
    expect_nxt   = expect_r;
    rows_nxt     = rows_r;
    act_rows_nxt = act_rows_r;
    bank_nxt     = bank_r;
    run_nxt      = run_r;

    res.status = (phase_r != PH_COUNT) ? cdtl_pkg::ST_LOADING : cdtl_pkg::ST_IDLE;
    res.rd_hit = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = {bank_r, addr32[POS_W-1:0]};
    ram_wdata  = load_word[ENTRY_WIDTH-1:0];

    if (item_en) begin
      case (op)
        cdtl_pkg::OP_LOAD: begin
          case (phase_r)
            PH_COUNT: begin
              if (bad_count) begin
                run_nxt    = 1'b1;
                res.status = cdtl_pkg::ST_REJECT;
              end else begin
                rows_nxt   = load_word[ROW_W-1:0];
                sum_nxt    = cdtl_pkg::SUM_SEED + load_word;
                phase_nxt  = PH_SUM;
                res.status = cdtl_pkg::ST_LOADING;
              end
            end
            PH_SUM: begin
              expect_nxt = load_word;
              pos_nxt    = '0;
              phase_nxt  = PH_ENTRY;
              res.status = cdtl_pkg::ST_LOADING;
            end
            PH_ENTRY: begin
              sum_nxt  = entry_sum;
              ram_we   = 1'b1;
              ram_addr = {~bank_r, pos_r};
              if (pos_r != last) begin
                pos_nxt    = pos_r + POS_W'(1);
                res.status = cdtl_pkg::ST_LOADING;
              end else begin
                phase_nxt = PH_COUNT;
                run_nxt   = 1'b1;
                if (entry_sum == expect_r) begin
                  bank_nxt     = ~bank_r;
                  act_rows_nxt = rows_r;
                  res.status   = cdtl_pkg::ST_COMMIT;
                end else begin
                  res.status = cdtl_pkg::ST_REJECT;
                end
              end
            end
            default: begin
              phase_nxt = PH_COUNT;
            end
          endcase
        end
        cdtl_pkg::OP_READ: begin
          if (rd_in_range) begin
            ram_re     = 1'b1;
            res.rd_hit = 1'b1;
          end
        end
        cdtl_pkg::OP_RUN: begin
          run_nxt = run_value;
        end
        default: begin
        end
      endcase
    end

    rows32      = 32'(act_rows_nxt);
    res.running = run_nxt;
    res.rows    = rows32[cdtl_pkg::OUT_ROW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COUNT;
      pos_r      <= '0;
      sum_r      <= '0;
      expect_r   <= '0;
      rows_r     <= '0;
      act_rows_r <= '0;
      bank_r     <= 1'b0;
      run_r      <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      sum_r      <= sum_nxt;
      expect_r   <= expect_nxt;
      rows_r     <= rows_nxt;
      act_rows_r <= act_rows_nxt;
      bank_r     <= bank_nxt;
      run_r      <= run_nxt;
    end
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ENTRY) |-> (pos_r <= last))
    else $error("Load position ran past the last entry.");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (item_en && phase_r == PH_ENTRY && !ram_re))
    else $error("Table write outside the entry phase.");

  a_commit_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_nxt != bank_r) |=>
      (32'(act_rows_r) >= 32'(MIN_ROWS) && 32'(act_rows_r) < 32'(ROW_CAPACITY)))
    else $error("Bank switched to a table with an illegal row count.");

endmodule

/* hw/rtl/checked_dac_table_loader.sv */
// Channel  Direction  Transfer when
// in_      input      in_valid && in_ready (op, load_word, read_address, run_value)
// out_     output     out_valid && out_ready (status, read_data, running, active_row_count)
//
// One item is accepted per cycle as long as results are taken; each item yields one result.
// After its transfer, a result passes through the table RAM read stage and then the output
// register. A result that is not taken holds the output register and one more item may
// enter the stage behind it before in_ready drops.
// Reset is synchronous and active low; it empties both stages and clears the table state,
// while the table RAM contents stay undefined until loaded.
module checked_dac_table_loader #(
  parameter int ROW_CAPACITY = 512,
  parameter int MIN_ROWS     = 29,
  parameter int ENTRY_WIDTH  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [cdtl_pkg::WORD_W-1:0]    in_load_word,
  input  logic [cdtl_pkg::ADDR_W-1:0]    in_read_address,
  input  logic                           in_run_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [cdtl_pkg::DATA_W-1:0]    out_read_data,
  output logic                           out_running,
  output logic [cdtl_pkg::OUT_ROW_W-1:0] out_active_row_count
);

  localparam int ROW_W = $clog2(ROW_CAPACITY);
  localparam int AW    = ROW_W + 2;

  logic                   accept;
  logic                   s_move;
  cdtl_pkg::res_t         res;
  logic                   ram_we;
  logic                   ram_re;
  logic [AW-1:0]          ram_addr;
  logic [ENTRY_WIDTH-1:0] ram_wdata;
  logic [ENTRY_WIDTH-1:0] ram_rdata;
  logic [31:0]            rd32;

  logic                            s_v_r;
  cdtl_pkg::res_t                  s_res_r;
  logic                            o_v_r;
  logic [1:0]                      o_status_r;
  logic [cdtl_pkg::DATA_W-1:0]     o_data_r;
  logic                            o_running_r;
  logic [cdtl_pkg::OUT_ROW_W-1:0]  o_rows_r;

  assign s_move   = s_v_r && (!o_v_r || out_ready);
  assign in_ready = !s_v_r || s_move;
  assign accept   = in_valid && in_ready;
  assign rd32     = 32'(ram_rdata);

  cdtl_ctrl #(
    .ROW_CAPACITY(ROW_CAPACITY),
    .MIN_ROWS    (MIN_ROWS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_en     (accept),
    .op          (in_op),
    .load_word   (in_load_word),
    .read_address(in_read_address),
    .run_value   (in_run_value),
    .res         (res),
    .ram_we      (ram_we),
    .ram_re      (ram_re),
    .ram_addr    (ram_addr),
    .ram_wdata   (ram_wdata)
  );

  cdtl_ram #(
    .WIDTH(ENTRY_WIDTH),
    .DEPTH(1 << AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      s_v_r <= accept || (s_v_r && !s_move);
      o_v_r <= s_move || (o_v_r && !out_ready);
    end
    if (accept) begin
      s_res_r <= res;
    end
    if (s_move) begin
      o_status_r  <= s_res_r.status;
      o_data_r    <= s_res_r.rd_hit ? rd32[cdtl_pkg::DATA_W-1:0] : '0;
      o_running_r <= s_res_r.running;
      o_rows_r    <= s_res_r.rows;
    end
  end

  assign out_valid            = o_v_r;
  assign out_status           = o_status_r;
  assign out_read_data        = o_data_r;
  assign out_running          = o_running_r;
  assign out_active_row_count = o_rows_r;

endmodule

/* dv/tb_checked_dac_table_loader.sv */
`timescale 1ns / 100ps

module tb_checked_dac_table_loader;

  localparam int ROW_CAPACITY = 512;
  localparam int MIN_ROWS = 29;
  localparam int BANK_ENTRIES = 2 * ROW_CAPACITY;
  localparam int BANK_AW = $clog2(BANK_ENTRIES);
  localparam int RANDOM_ITEMS = 40;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]                     status;
    logic [cdtl_pkg::DATA_W-1:0]    read_data;
    logic                           running;
    logic [cdtl_pkg::OUT_ROW_W-1:0] rows;
  } table_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     in_op;
  logic [cdtl_pkg::WORD_W-1:0]    in_load_word;
  logic [cdtl_pkg::ADDR_W-1:0]    in_read_address;
  logic                           in_run_value;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [1:0]                     out_status;
  logic [cdtl_pkg::DATA_W-1:0]    out_read_data;
  logic                           out_running;
  logic [cdtl_pkg::OUT_ROW_W-1:0] out_active_row_count;

  // Predicted state of the table loader.
  logic [cdtl_pkg::DATA_W-1:0]    table_banks [0:1][0:BANK_ENTRIES-1];
  logic                           live_bank;
  int unsigned                    word_index;
  logic [31:0]                    sum_so_far;
  logic [31:0]                    sum_target;
  logic [cdtl_pkg::OUT_ROW_W-1:0] pending_rows;
  logic [cdtl_pkg::OUT_ROW_W-1:0] live_rows;
  logic                           run_state;

  table_result_t pending_results[$];
  int            error_count = 0;
  int            items_sent = 0;
  int            burst_left = 0;
  int            table_rows = 0;
  int            idle_cycles = 0;
  int            stall_left = 0;
  int            stall_mode = 0;

  checked_dac_table_loader #(
    .ROW_CAPACITY(ROW_CAPACITY),
    .MIN_ROWS(MIN_ROWS),
    .ENTRY_WIDTH(cdtl_pkg::DATA_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_op(in_op),
    .in_load_word(in_load_word),
    .in_read_address(in_read_address),
    .in_run_value(in_run_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_read_data(out_read_data),
    .out_running(out_running),
    .out_active_row_count(out_active_row_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void predict_table_result(logic [1:0] op, logic [31:0] word,
                                               logic [cdtl_pkg::ADDR_W-1:0] addr,
                                               logic run_val);
    table_result_t res;
    int unsigned   pos;
    res.read_data = '0;
    if (op == cdtl_pkg::OP_LOAD) begin
      if (word_index == 0) begin
        if (word[31] || word < MIN_ROWS || word >= ROW_CAPACITY) begin
          run_state = 1'b1;
          res.status = cdtl_pkg::ST_REJECT;
        end else begin
          pending_rows = word[cdtl_pkg::OUT_ROW_W-1:0];
          sum_so_far = cdtl_pkg::SUM_SEED + word;
          word_index = 1;
          res.status = cdtl_pkg::ST_LOADING;
        end
      end else if (word_index == 1) begin
        sum_target = word;
        word_index = 2;
        res.status = cdtl_pkg::ST_LOADING;
      end else begin
        pos = word_index - 2;
        sum_so_far = sum_so_far + word + (pos >> 1) + (pos & 1);
        table_banks[!live_bank][pos[BANK_AW-1:0]] = word[cdtl_pkg::DATA_W-1:0];
        if (pos < 2 * pending_rows - 1) begin
          word_index = word_index + 1;
          res.status = cdtl_pkg::ST_LOADING;
        end else begin
          word_index = 0;
          run_state = 1'b1;
          if (sum_so_far == sum_target) begin
            live_bank = !live_bank;
            live_rows = pending_rows;
            res.status = cdtl_pkg::ST_COMMIT;
          end else begin
            res.status = cdtl_pkg::ST_REJECT;
          end
        end
      end
    end else begin
      if (op == cdtl_pkg::OP_READ && addr < 2 * live_rows) begin
        res.read_data = table_banks[live_bank][addr];
      end else if (op == cdtl_pkg::OP_RUN) begin
        run_state = run_val;
      end
      res.status = (word_index != 0) ? cdtl_pkg::ST_LOADING : cdtl_pkg::ST_IDLE;
    end
    res.running = run_state;
    res.rows = live_rows;
    pending_results.push_back(res);
  endfunction

  always @(posedge clk) begin
    table_result_t exp_res;
    if (!rst_n) begin
      live_bank <= 1'b0;
      word_index <= 0;
      sum_so_far <= '0;
      sum_target <= '0;
      pending_rows <= '0;
      live_rows <= '0;
      run_state <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d read_data %0h", out_status, out_read_data);
          error_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, out_status);
            error_count++;
          end
          if (out_read_data !== exp_res.read_data) begin
            $error("read_data: expected %0h, got %0h", exp_res.read_data, out_read_data);
            error_count++;
          end
          if (out_running !== exp_res.running) begin
            $error("running: expected %0d, got %0d", exp_res.running, out_running);
            error_count++;
          end
          if (out_active_row_count !== exp_res.rows) begin
            $error("active_row_count: expected %0d, got %0d", exp_res.rows,
                   out_active_row_count);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_table_result(in_op, in_load_word, in_read_address, in_run_value);
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: out_ready <= (stall_left % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("checked_dac_table_loader test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [31:0] word,
                           input logic [cdtl_pkg::ADDR_W-1:0] addr, input logic run_val);
    int gap;
    in_valid <= 1'b1;
    in_op <= op;
    in_load_word <= word;
    in_read_address <= addr;
    in_run_value <= run_val;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_load_word(input logic [31:0] word);
    send_item(cdtl_pkg::OP_LOAD, word, cdtl_pkg::ADDR_W'($urandom), 1'($urandom));
  endtask

  task automatic send_side_item();
    logic [cdtl_pkg::ADDR_W-1:0] addr;
    int                          pick;
    pick = $urandom_range(0, 9);
    if (table_rows > 0 && $urandom_range(0, 3) != 0) begin
      addr = cdtl_pkg::ADDR_W'($urandom_range(0, 2 * table_rows - 1));
    end else begin
      addr = cdtl_pkg::ADDR_W'($urandom_range(0, 1023));
    end
    if (pick < 6) begin
      send_item(cdtl_pkg::OP_READ, $urandom, addr, 1'($urandom));
    end else if (pick < 9) begin
      send_item(cdtl_pkg::OP_RUN, $urandom, addr, 1'($urandom));
    end else begin
      send_item(OP_UNUSED, $urandom, addr, 1'($urandom));
    end
  endtask

  task automatic load_table(input int rows, input bit bad_sum, input int side_pct);
    logic [31:0] entries[$];
    logic [31:0] sum;
    logic [31:0] entry;
    int          i;
    sum = cdtl_pkg::SUM_SEED + rows;
    for (i = 0; i < 2 * rows; i++) begin
      case ($urandom_range(0, 11))
        0: entry = 32'h0000_0000;
        1: entry = 32'hFFFF_FFFF;
        2: entry = 32'h0000_FFFF;
        3: entry = 32'h0000_8000;
        4: entry = 32'h7FFF_0000;
        default: entry = $urandom;
      endcase
      entries.push_back(entry);
      sum = sum + entry + (i / 2) + (i % 2);
    end
    if (bad_sum) begin
      sum = sum ^ (32'h1 << $urandom_range(0, 31));
    end
    send_load_word(rows);
    send_load_word(sum);
    foreach (entries[k]) begin
      if ($urandom_range(0, 99) < side_pct) begin
        send_side_item();
      end
      send_load_word(entries[k]);
    end
    if (!bad_sum) begin
      table_rows = rows;
    end
  endtask

  task automatic test_idle_ops();
    send_item(cdtl_pkg::OP_READ, $urandom, 10'd0, 1'b0);
    send_item(cdtl_pkg::OP_READ, $urandom, 10'd1023, 1'b1);
    send_item(cdtl_pkg::OP_RUN, $urandom, cdtl_pkg::ADDR_W'($urandom), 1'b1);
    send_item(cdtl_pkg::OP_RUN, $urandom, cdtl_pkg::ADDR_W'($urandom), 1'b0);
    send_item(OP_UNUSED, 32'hFFFF_FFFF, 10'd1023, 1'b1);
  endtask

  task automatic test_row_count_limits();
    send_load_word(32'd0);
    send_load_word(MIN_ROWS - 1);
    send_item(cdtl_pkg::OP_RUN, $urandom, cdtl_pkg::ADDR_W'($urandom), 1'b0);
    send_load_word(ROW_CAPACITY);
    send_load_word(32'h8000_0000);
    send_load_word(32'h8000_001D);
    send_load_word(32'hFFFF_FFFF);
    send_load_word(32'h7FFF_FFFF);
  endtask

  task automatic test_smallest_table();
    load_table(MIN_ROWS, 1'b0, 0);
    send_item(cdtl_pkg::OP_READ, $urandom, 10'd0, 1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, 10'd1, 1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, cdtl_pkg::ADDR_W'(2 * MIN_ROWS - 1), 1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, cdtl_pkg::ADDR_W'(2 * MIN_ROWS), 1'($urandom));
  endtask

  task automatic test_bad_checksum();
    load_table(MIN_ROWS + 1, 1'b1, 0);
    send_item(cdtl_pkg::OP_READ, $urandom, cdtl_pkg::ADDR_W'(2 * MIN_ROWS - 1), 1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, cdtl_pkg::ADDR_W'(2 * MIN_ROWS), 1'($urandom));
  endtask

  task automatic test_random_traffic();
    int start_count;
    int pick;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        load_table($urandom_range(MIN_ROWS, MIN_ROWS + 12), $urandom_range(0, 4) == 0,
                   $urandom_range(0, 25));
      end else if (pick < 8) begin
        send_side_item();
      end else begin
        case ($urandom_range(0, 2))
          0: send_load_word($urandom_range(0, MIN_ROWS - 1));
          1: send_load_word($urandom_range(ROW_CAPACITY, 4095));
          default: send_load_word($urandom | 32'h8000_0000);
        endcase
      end
    end
  endtask

  task automatic test_largest_table();
    load_table(ROW_CAPACITY - 1, 1'b0, 3);
    send_item(cdtl_pkg::OP_READ, $urandom, 10'd0, 1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, cdtl_pkg::ADDR_W'(2 * ROW_CAPACITY - 3),
              1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, cdtl_pkg::ADDR_W'(2 * ROW_CAPACITY - 2),
              1'($urandom));
    send_item(cdtl_pkg::OP_READ, $urandom, 10'd1023, 1'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = cdtl_pkg::OP_LOAD;
    in_load_word = '0;
    in_read_address = '0;
    in_run_value = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ops();
    test_row_count_limits();
    test_smallest_table();
    test_bad_checksum();
    test_random_traffic();
    test_largest_table();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("checked_dac_table_loader test passed");
    end else begin
      $display("checked_dac_table_loader test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/cdtl_pkg.sv
hw/rtl/cdtl_ram.sv
hw/rtl/cdtl_ctrl.sv
hw/rtl/checked_dac_table_loader.sv
dv/tb_checked_dac_table_loader.sv
